[hdl/dwtm_pkg.sv]
// Shared constants, types and the sine table generator for the dual wavetable tone mixer.
package dwtm_pkg;

    localparam int STEP_W         = 26;
    localparam int VOL_W          = 12;
    localparam int DAC_W          = 12;
    localparam int FRAC_W         = 16;
    localparam int SAMPLE_W       = 16;
    localparam int TDATA_W        = 16;
    localparam int CFG_IDX_W      = 1;
    localparam int MIX_SHIFT      = 17;
    localparam int MID_CODE       = 2048;
    localparam int AMP            = 32767;
    localparam int TABLE_SIZE_DEF = 1000;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_A = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_B = 1'b1;

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    // pipeline control shared by all stages
    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic advance;  // every stage moves forward this cycle
    } t_pipe_ctl;

    // (a*b) >> 62, low 64 bits kept
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // restoring long division, quotient only
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], a[j]};
            if (rem >= {1'b0, b}) begin
                rem  = rem - {1'b0, b};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // floor(AMP * sin(pi/2 * t/n)) for 0 <= t <= n
    function automatic logic [31:0] quarter_sine(input logic [31:0] t, input logic [31:0] n);
        logic [63:0] a, q1, r1, x, y, y2, term, sum, nn, dv, prod;
        if (t == 32'd0) begin
            return 32'd0;
        end
        if (t >= n) begin
            return 32'(AMP);
        end
        nn = {32'd0, n};
        a  = {t, 32'd0};
        q1 = udiv64(a, nn);
        r1 = a - q1 * nn;
        x  = (q1 << 30) + udiv64(r1 << 30, nn);
        y  = mul_q62(x, HALF_PI_Q62);
        y2 = mul_q62(y, y);
        term = y;
        sum  = y;
        for (int k = 1; k <= 14; k++) begin
            dv   = 64'(2 * k) * 64'(2 * k + 1);
            term = udiv64(mul_q62(term, y2), dv);
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        prod = mul_q62(sum, 64'(AMP));
        return prod[31:0];
    endfunction

    // entry i of an n-entry table: 32767*sin(2*pi*i/n), truncated toward zero
    function automatic logic [SAMPLE_W-1:0] sine_entry(input int i, input int n);
        logic [31:0] m, t, v, nu;
        logic        neg;
        nu  = 32'(n);
        m   = 32'(i);
        neg = 1'b0;
        if (2 * i == n) begin
            return '0;
        end
        if (2 * i > n) begin
            m   = nu - 32'(i);
            neg = 1'b1;
        end
        t = 32'd4 * m;
        if (t > nu) begin
            t = 32'd2 * nu - t;
        end
        v = quarter_sine(t, nu);
        return neg ? SAMPLE_W'(-v) : v[SAMPLE_W-1:0];
    endfunction

endpackage

[hdl/dwtm_phase.sv]
// Two 10.16 (IDX_W.16) phase accumulators with step saturation, wrap and registered table index.
module dwtm_phase
    import dwtm_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pipe_ctl        i_ctl,
    input  logic [STEP_W-1:0] i_step_a,
    input  logic [STEP_W-1:0] i_step_b,
    output logic [IDX_W-1:0] o_idx_a,
    output logic [IDX_W-1:0] o_idx_b
);

    localparam int PH_W = IDX_W + FRAC_W;
    localparam int WW   = ((PH_W > STEP_W) ? PH_W : STEP_W) + 1;
    localparam logic [WW-1:0] LEN = WW'(TABLE_SIZE) << FRAC_W;

    logic [PH_W-1:0]  r_phase_a, r_phase_b;
    logic [PH_W-1:0]  n_phase_a, n_phase_b;
    logic [IDX_W-1:0] r_idx_a, r_idx_b;

    function automatic logic [PH_W-1:0] next_phase(input logic [PH_W-1:0] ph,
                                                   input logic [STEP_W-1:0] st);
        logic [WW-1:0] st_x, sat, sum, wr;
        st_x = WW'(st);
        sat  = (st_x >= LEN) ? (LEN - WW'(1)) : st_x;
        sum  = WW'(ph) + sat;
        wr   = (sum >= LEN) ? (sum - LEN) : sum;
        return (st == '0) ? '0 : wr[PH_W-1:0];
    endfunction

    assign n_phase_a = next_phase(r_phase_a, i_step_a);
    assign n_phase_b = next_phase(r_phase_b, i_step_b);

    // advance phase state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_a <= '0;
            r_phase_b <= '0;
        end else if (i_ctl.accept) begin
            r_phase_a <= n_phase_a;
            r_phase_b <= n_phase_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_idx_a <= n_phase_a[PH_W-1:FRAC_W];
            r_idx_b <= n_phase_b[PH_W-1:FRAC_W];
        end
    end

    assign o_idx_a = r_idx_a;
    assign o_idx_b = r_idx_b;

endmodule

[hdl/dwtm_sine_rom.sv]
// Constant sine table with two registered read ports.
module dwtm_sine_rom
    import dwtm_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  logic [IDX_W-1:0]           i_idx_a,
    input  logic [IDX_W-1:0]           i_idx_b,
    output logic signed [SAMPLE_W-1:0] o_smp_a,
    output logic signed [SAMPLE_W-1:0] o_smp_b
);

    logic [SAMPLE_W-1:0]        w_tab [TABLE_SIZE];
    logic signed [SAMPLE_W-1:0] r_smp_a, r_smp_b;

    for (genvar gi = 0; gi < TABLE_SIZE; gi++) begin : g_tab
        localparam logic [SAMPLE_W-1:0] ENTRY = sine_entry(gi, TABLE_SIZE);
        assign w_tab[gi] = ENTRY;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_smp_a <= $signed(w_tab[i_idx_a]);
            r_smp_b <= $signed(w_tab[i_idx_b]);
        end
    end

    assign o_smp_a = r_smp_a;
    assign o_smp_b = r_smp_b;

endmodule

[hdl/dwtm_mix.sv]
// Sum of both voices, volume scaling, shift and midscale offset into the output register.
module dwtm_mix
    import dwtm_pkg::*;
(
    input  logic                       i_clk,
    input  t_pipe_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_smp_a,
    input  logic signed [SAMPLE_W-1:0] i_smp_b,
    input  logic [VOL_W-1:0]           i_vol,
    output logic [DAC_W-1:0]           o_dac
);

    localparam int SUM_W  = SAMPLE_W + 1;
    localparam int PROD_W = SUM_W + VOL_W + 1;

    logic signed [SUM_W-1:0]  w_sum;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shr;
    logic [DAC_W-1:0]         n_dac;
    logic [DAC_W-1:0]         r_dac;

    assign w_sum  = SUM_W'(i_smp_a) + SUM_W'(i_smp_b);
    assign w_prod = PROD_W'(w_sum) * $signed({1'b0, i_vol});
    // floor shift, then offset to midscale; wrap to the code width
    assign w_shr  = w_prod >>> MIX_SHIFT;
    assign n_dac  = w_shr[DAC_W-1:0] + DAC_W'(MID_CODE);

    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_dac <= n_dac;
        end
    end

    assign o_dac = r_dac;

endmodule

[hdl/dual_wavetable_tone_mixer_core.sv]
// Top level of the dual wavetable tone mixer: step registers, pipeline control, stream ports.
//
// Usage:
//   Each slave-side transaction is one sample tick; s_tdata[11:0] carries the volume.
//   Each tick advances both 10.16 phase accumulators by their step registers, reads the
//   sine table at both integer phases, sums the two samples, scales by the volume, shifts
//   right by 17 and offsets by 2048. One master-side transaction carries the 12-bit DAC code.
//   Steps are written through the plain write port (index 0 = channel A, 1 = channel B);
//   write them only while the pipeline is empty. A zero step parks that channel at phase 0.
//   Throughput: one transaction per cycle while the receiver keeps m_tready high. Each result
//   passes the index register, the table read register and the output register before
//   m_tvalid rises with it.
//   All stages advance together; when m_tready is low with a result held, s_tready drops
//   and the whole pipeline holds, so nothing is lost or repeated.
//   Reset (synchronous, active low) clears both phases, both steps and all valid bits.
//   The sine table is constant logic; no fill pass is needed after reset.
module dual_wavetable_tone_mixer_core
    import dwtm_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [STEP_W-1:0]    i_cfg_data,
    // slave side
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [TDATA_W-1:0]   s_tdata,   // [11:0] volume, [15:12] zero
    // master side
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [TDATA_W-1:0]   m_tdata    // [11:0] dac_code, [15:12] zero
);

    localparam int IDX_W = $clog2(TABLE_SIZE);

    logic [STEP_W-1:0] r_step_a, r_step_b;
    logic              r_v1, r_v2, r_vout;
    logic [VOL_W-1:0]  r_vol1, r_vol2;
    t_pipe_ctl         w_ctl;

    logic [IDX_W-1:0]           w_idx_a, w_idx_b;
    logic signed [SAMPLE_W-1:0] w_smp_a, w_smp_b;
    logic [DAC_W-1:0]           w_dac;

    // hold everything while a finished result waits for the receiver
    assign w_ctl.advance = !r_vout || m_tready;
    assign w_ctl.accept  = s_tvalid && w_ctl.advance;
    assign s_tready      = w_ctl.advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_a <= '0;
            r_step_b <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_A: r_step_a <= i_cfg_data;
                CFG_STEP_B: r_step_b <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // valid bits travel alongside the data stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_vout <= 1'b0;
        end else if (w_ctl.advance) begin
            r_v1   <= w_ctl.accept;
            r_v2   <= r_v1;
            r_vout <= r_v2;
        end
    end

    // volume follows its tick through the index and table stages
    always_ff @(posedge i_clk) begin
        if (w_ctl.advance) begin
            r_vol1 <= s_tdata[VOL_W-1:0];
            r_vol2 <= r_vol1;
        end
    end

    dwtm_phase #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_phase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_step_a (r_step_a),
        .i_step_b (r_step_b),
        .o_idx_a  (w_idx_a),
        .o_idx_b  (w_idx_b)
    );

    dwtm_sine_rom #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_rom (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_idx_a (w_idx_a),
        .i_idx_b (w_idx_b),
        .o_smp_a (w_smp_a),
        .o_smp_b (w_smp_b)
    );

    dwtm_mix u_mix (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_smp_a (w_smp_a),
        .i_smp_b (w_smp_b),
        .i_vol   (r_vol2),
        .o_dac   (w_dac)
    );

    assign m_tvalid = r_vout;
    assign m_tdata  = TDATA_W'(w_dac);

    // a zero step parks the channel on table entry zero
    a_zero_step_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.accept && r_step_a == '0) |=> (w_idx_a == '0))
        else $error("channel A index not zero after zero-step tick");

    a_zero_step_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.accept && r_step_b == '0) |=> (w_idx_b == '0))
        else $error("channel B index not zero after zero-step tick");

    // the table index never leaves the table
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (32'(w_idx_a) < TABLE_SIZE && 32'(w_idx_b) < TABLE_SIZE))
        else $error("table index out of range");

    // a result appears only from a filled table stage
    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_v2))
        else $error("output valid without a tick in the table stage");

endmodule
